// ----- rtl/core/z80_index_prefix_executor_assert.svh -----
// Assertion macros used by the checker of this block.
`ifndef Z80_INDEX_PREFIX_EXECUTOR_ASSERT_SVH
`define Z80_INDEX_PREFIX_EXECUTOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define ZIPE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zipe assertion failed");

// Next-cycle implication, disabled in reset.
`define ZIPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zipe assertion failed");

`endif

// ----- rtl/core/zipe_pkg.sv -----
`default_nettype none
package zipe_pkg;

  typedef enum logic [4:0] {
    K_UNKNOWN, K_LD_IMM16, K_ST_NN, K_LD_NN, K_ADD16, K_INC16, K_DEC16, K_INC_H,
    K_LDH_N, K_LDL_N, K_REG_FROM_IX, K_IX_FROM_REG, K_ALU_IXL, K_INCDEC_MEM,
    K_ST_N, K_LD_R_MEM, K_ST_R_MEM, K_ALU_MEM, K_JP, K_POP, K_PUSH,
    K_CB_SET, K_CB_RES, K_CB_BIT
  } kind_t;

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0, ALU_ADC = 3'd1, ALU_SUB = 3'd2, ALU_SBC = 3'd3,
    ALU_AND = 3'd4, ALU_XOR = 3'd5, ALU_OR  = 3'd6, ALU_CP  = 3'd7
  } alu_op_t;

  localparam logic [2:0] REG_B = 3'd0;
  localparam logic [2:0] REG_C = 3'd1;
  localparam logic [2:0] REG_D = 3'd2;
  localparam logic [2:0] REG_E = 3'd3;
  localparam logic [2:0] REG_H = 3'd4;
  localparam logic [2:0] REG_L = 3'd5;
  localparam logic [2:0] REG_A = 3'd7;

  localparam logic [7:0] OP_CB = 8'hCB;

  // One decoded instruction word in the queue.
  typedef struct packed {
    kind_t      kind;
    logic       sel;
    logic [2:0] rsel;
    logic       half_low;
    alu_op_t    aluop;
    logic [2:0] bitn;
    logic [7:0] disp;
    logic [7:0] imm_lo;
    logic [7:0] imm_hi;
    logic [1:0] adv;
    logic [4:0] tst;
  } item_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } exec_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/zipe_front.sv -----
`default_nettype none
module zipe_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               index_select,
  input  wire logic [7:0]         opcode,
  input  wire logic signed [7:0]  displacement,
  input  wire logic [7:0]         immediate_low,
  input  wire logic [7:0]         immediate_high,
  input  wire logic [7:0]         bit_opcode,
  input  wire zipe_pkg::exec_stat_t stat,
  output logic                    q_valid,
  output zipe_pkg::item_t         q_item
);
  import zipe_pkg::*;

  item_t      dec;
  item_t      q [2];
  logic       wptr, rptr;
  logic [1:0] cnt;
  logic       push;

  always_comb begin
    dec          = '0;
    dec.sel      = index_select;
    dec.rsel     = opcode[5:3];
    dec.half_low = opcode[0];
    dec.aluop    = alu_op_t'(opcode[5:3]);
    dec.bitn     = bit_opcode[5:3];
    dec.disp     = displacement;
    dec.imm_lo   = immediate_low;
    dec.imm_hi   = immediate_high;
    dec.adv      = 2'd1;
    dec.tst      = 5'd0;
    dec.kind     = K_UNKNOWN;
    unique case (opcode) inside
      8'h21: begin dec.kind = K_LD_IMM16; dec.adv = 2'd3; dec.tst = 5'd14; end
      8'h22: begin dec.kind = K_ST_NN; dec.adv = 2'd3; dec.tst = 5'd20; end
      8'h2A: begin dec.kind = K_LD_NN; dec.adv = 2'd3; dec.tst = 5'd20; end
      8'h09, 8'h19, 8'h29, 8'h39: begin dec.kind = K_ADD16; dec.tst = 5'd15; end
      8'h23: begin dec.kind = K_INC16; dec.tst = 5'd10; end
      8'h2B: begin dec.kind = K_DEC16; dec.tst = 5'd10; end
      8'h24: begin dec.kind = K_INC_H; dec.tst = 5'd8; end
      8'h26: begin dec.kind = K_LDH_N; dec.adv = 2'd2; dec.tst = 5'd11; end
      8'h2E: begin dec.kind = K_LDL_N; dec.adv = 2'd2; dec.tst = 5'd11; end
      8'h54, 8'h5D, 8'h5C, 8'h4C, 8'h7C, 8'h7D: begin
        dec.kind = K_REG_FROM_IX; dec.tst = 5'd8;
      end
      8'h69, 8'h6F, 8'h60, 8'h67: begin
        dec.kind = K_IX_FROM_REG; dec.rsel = opcode[2:0]; dec.half_low = opcode[3];
        dec.tst = 5'd8;
      end
      8'hB5: begin dec.kind = K_ALU_IXL; dec.tst = 5'd8; end
      8'h34, 8'h35: begin dec.kind = K_INCDEC_MEM; dec.adv = 2'd2; dec.tst = 5'd23; end
      8'h36: begin dec.kind = K_ST_N; dec.adv = 2'd3; dec.tst = 5'd19; end
      8'h46, 8'h4E, 8'h56, 8'h5E, 8'h66, 8'h6E, 8'h7E: begin
        dec.kind = K_LD_R_MEM; dec.adv = 2'd2; dec.tst = 5'd19;
      end
      8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h77: begin
        dec.kind = K_ST_R_MEM; dec.rsel = opcode[2:0]; dec.adv = 2'd2; dec.tst = 5'd19;
      end
      8'h86, 8'h8E, 8'h96, 8'h9E, 8'hA6, 8'hAE, 8'hB6, 8'hBE: begin
        dec.kind = K_ALU_MEM; dec.adv = 2'd2; dec.tst = 5'd19;
      end
      8'hE9: begin dec.kind = K_JP; dec.adv = 2'd0; dec.tst = 5'd8; end
      8'hE1: begin dec.kind = K_POP; dec.tst = 5'd14; end
      8'hE5: begin dec.kind = K_PUSH; dec.tst = 5'd15; end
      OP_CB: begin
        dec.adv = 2'd3;
        if (bit_opcode[7:6] == 2'b11) begin
          dec.kind = K_CB_SET; dec.tst = 5'd23;
        end else if (bit_opcode[7:6] == 2'b10) begin
          dec.kind = K_CB_RES; dec.tst = 5'd23;
        end else if (bit_opcode[7:6] == 2'b01) begin
          dec.kind = K_CB_BIT; dec.tst = 5'd20;
        end
      end
      default: ;
    endcase
  end

  assign in_stall = (cnt == 2'd2) || stat.clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = q[rptr];

  always_ff @(posedge clk) begin
    if (push) q[wptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (stat.pop) rptr <= ~rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, stat.pop};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/zipe_exec.sv -----
`default_nettype none
module zipe_exec #(
  parameter int ADDRESS_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire zipe_pkg::item_t q_item,
  output zipe_pkg::exec_stat_t stat,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [4:0]           t_states,
  output logic                 unknown_opcode,
  output logic [15:0]          ix_value,
  output logic [15:0]          iy_value,
  output logic [15:0]          acc_and_flags,
  output logic [15:0]          bc_value,
  output logic [15:0]          de_value,
  output logic [15:0]          hl_value,
  output logic [15:0]          sp_value,
  output logic [15:0]          pc_value,
  output logic [7:0]           refresh_value
);
  import zipe_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_STEP2 = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  typedef struct packed {
    logic [15:0] ix, iy, sp, pc;
    logic [7:0]  a, f, b, c, d, e, h, l, r;
  } regs_t;

  state_t                  state;
  item_t                   cur;
  regs_t                   regs, regs_next;
  logic [ADDRESS_BITS-1:0] clr_cnt;
  logic [7:0]              mem [2**ADDRESS_BITS];
  logic [7:0]              rdata, data0;
  logic                    mem_we;
  logic [15:0]             mem_waddr, mem_raddr;
  logic [7:0]              mem_wdata, fin_wdata;
  logic [15:0]             idx, ea, nn, a0, a1, idx_new, add_y;
  logic [7:0]              wd0, wd1;
  logic                    fin_go;

  function automatic logic [7:0] reg_rd(input regs_t rg, input logic [2:0] code);
    logic [7:0] v;
    begin
      unique case (code)
        REG_B:   v = rg.b;
        REG_C:   v = rg.c;
        REG_D:   v = rg.d;
        REG_E:   v = rg.e;
        REG_H:   v = rg.h;
        REG_L:   v = rg.l;
        REG_A:   v = rg.a;
        default: v = 8'h00;
      endcase
      return v;
    end
  endfunction

  function automatic regs_t reg_wr(input regs_t rg, input logic [2:0] code,
                                   input logic [7:0] v);
    regs_t o;
    begin
      o = rg;
      unique case (code)
        REG_B:   o.b = v;
        REG_C:   o.c = v;
        REG_D:   o.d = v;
        REG_E:   o.e = v;
        REG_H:   o.h = v;
        REG_L:   o.l = v;
        REG_A:   o.a = v;
        default: ;
      endcase
      return o;
    end
  endfunction

  // Result in the high byte, flags in the low byte.
  function automatic logic [15:0] inc_dec8(input logic [7:0] v, input logic dec,
                                           input logic [7:0] f);
    logic [7:0] r, nf;
    begin
      r  = dec ? v - 8'd1 : v + 8'd1;
      nf = f & 8'h29;
      nf[7] = r[7];
      nf[6] = (r == 8'h00);
      nf[1] = dec;
      nf[4] = dec ? (r[3:0] == 4'hF) : (r[3:0] == 4'h0);
      nf[2] = dec ? (r == 8'h7F) : (r == 8'h80);
      return {r, nf};
    end
  endfunction

  function automatic logic [15:0] alu8(input alu_op_t op, input logic [7:0] a,
                                       input logic [7:0] f, input logic [7:0] v);
    logic       c;
    logic [8:0] r9;
    logic [4:0] h5;
    logic [7:0] r, nf;
    begin
      c  = (op == ALU_ADC || op == ALU_SBC) ? f[0] : 1'b0;
      nf = f & 8'h28;
      r9 = 9'd0;
      h5 = 5'd0;
      r  = 8'h00;
      unique case (op) inside
        ALU_ADD, ALU_ADC: begin
          r9 = {1'b0, a} + {1'b0, v} + {8'd0, c};
          h5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c};
          r  = r9[7:0];
          nf[4] = h5[4];
          nf[2] = ~(a[7] ^ v[7]) & (a[7] ^ r[7]);
          nf[0] = r9[8];
        end
        ALU_SUB, ALU_SBC, ALU_CP: begin
          r9 = {1'b0, a} - {1'b0, v} - {8'd0, c};
          h5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, c};
          r  = r9[7:0];
          nf[4] = h5[4];
          nf[2] = (a[7] ^ v[7]) & (a[7] ^ r[7]);
          nf[1] = 1'b1;
          nf[0] = r9[8];
        end
        ALU_AND: begin r = a & v; nf[4] = 1'b1; nf[2] = ~^r; end
        ALU_XOR: begin r = a ^ v; nf[2] = ~^r; end
        default: begin r = a | v; nf[2] = ~^r; end
      endcase
      nf[7] = r[7];
      nf[6] = (r == 8'h00);
      return {(op == ALU_CP) ? a : r, nf};
    end
  endfunction

  assign idx = cur.sel ? regs.iy : regs.ix;
  assign ea  = idx + {{8{cur.disp[7]}}, cur.disp};
  assign nn  = {cur.imm_hi, cur.imm_lo};

  // Memory access plan per kind: first and second address, store data.
  always_comb begin
    a0  = ea;
    a1  = ea;
    wd0 = reg_rd(regs, cur.rsel);
    wd1 = idx[7:0];
    unique case (cur.kind) inside
      K_ST_NN, K_LD_NN: begin a0 = nn; a1 = nn + 16'd1; wd0 = idx[7:0]; wd1 = idx[15:8]; end
      K_POP:   begin a0 = regs.sp; a1 = regs.sp + 16'd1; end
      K_PUSH:  begin a0 = regs.sp - 16'd1; a1 = regs.sp - 16'd2; wd0 = idx[15:8]; end
      K_ST_N:  wd0 = cur.imm_lo;
      default: ;
    endcase
  end

  assign fin_go = (state == ST_FIN) && (!out_valid || !out_stall);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = a0;
    mem_wdata = wd0;
    mem_raddr = a1;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = 16'(clr_cnt);
        mem_wdata = 8'h00;
      end
      ST_EXEC: begin
        mem_raddr = a0;
        mem_we    = (cur.kind == K_ST_NN) || (cur.kind == K_PUSH) ||
                    (cur.kind == K_ST_N) || (cur.kind == K_ST_R_MEM);
      end
      ST_STEP2: begin
        mem_waddr = a1;
        mem_wdata = wd1;
        mem_we    = (cur.kind == K_ST_NN) || (cur.kind == K_PUSH);
      end
      ST_FIN: begin
        mem_waddr = ea;
        mem_wdata = fin_wdata;
        mem_we    = fin_go && ((cur.kind == K_INCDEC_MEM) || (cur.kind == K_CB_SET) ||
                               (cur.kind == K_CB_RES));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr[ADDRESS_BITS-1:0]] <= mem_wdata;
    rdata <= mem[mem_raddr[ADDRESS_BITS-1:0]];
    if (state == ST_STEP2) data0 <= rdata;
  end

  // BC, DE, the index itself and SP sit in opcode bits 5:4.
  always_comb begin
    unique case (cur.rsel[2:1])
      2'b00:   add_y = {regs.b, regs.c};
      2'b01:   add_y = {regs.d, regs.e};
      2'b10:   add_y = idx;
      default: add_y = regs.sp;
    endcase
  end

  always_comb begin
    logic [16:0] s17;
    logic [12:0] s13;
    logic [15:0] t16;
    regs_next = regs;
    idx_new   = idx;
    fin_wdata = data0;
    s17 = {1'b0, idx} + {1'b0, add_y};
    s13 = {1'b0, idx[11:0]} + {1'b0, add_y[11:0]};
    t16 = 16'h0000;
    case (cur.kind)
      K_LD_IMM16: idx_new = nn;
      K_LD_NN, K_POP: idx_new = {rdata, data0};
      K_ADD16: begin
        idx_new = s17[15:0];
        regs_next.f = (regs.f & 8'hEC) | {3'b000, s13[12], 3'b000, s17[16]};
      end
      K_INC16: idx_new = idx + 16'd1;
      K_DEC16: idx_new = idx - 16'd1;
      K_INC_H: begin
        t16 = inc_dec8(idx[15:8], 1'b0, regs.f);
        idx_new = {t16[15:8], idx[7:0]};
        regs_next.f = t16[7:0];
      end
      K_LDH_N: idx_new = {cur.imm_lo, idx[7:0]};
      K_LDL_N: idx_new = {idx[15:8], cur.imm_lo};
      K_REG_FROM_IX:
        regs_next = reg_wr(regs, cur.rsel, cur.half_low ? idx[7:0] : idx[15:8]);
      K_IX_FROM_REG:
        idx_new = cur.half_low ? {idx[15:8], reg_rd(regs, cur.rsel)}
                               : {reg_rd(regs, cur.rsel), idx[7:0]};
      K_ALU_IXL, K_ALU_MEM: begin
        t16 = alu8(cur.aluop, regs.a, regs.f,
                   (cur.kind == K_ALU_IXL) ? idx[7:0] : data0);
        regs_next.a = t16[15:8];
        regs_next.f = t16[7:0];
      end
      K_INCDEC_MEM: begin
        // opcode bit 0 tells decrement from increment
        t16 = inc_dec8(data0, cur.half_low, regs.f);
        fin_wdata = t16[15:8];
        regs_next.f = t16[7:0];
      end
      K_LD_R_MEM: regs_next = reg_wr(regs, cur.rsel, data0);
      K_CB_SET: fin_wdata = data0 | (8'h01 << cur.bitn);
      K_CB_RES: fin_wdata = data0 & ~(8'h01 << cur.bitn);
      K_CB_BIT: regs_next.f = (regs.f & 8'hBD) | 8'h10 |
                              {1'b0, ~data0[cur.bitn], 6'b000000};
      default: ;
    endcase
    if (cur.sel) regs_next.iy = idx_new;
    else         regs_next.ix = idx_new;
    if (cur.kind == K_POP)  regs_next.sp = regs.sp + 16'd2;
    if (cur.kind == K_PUSH) regs_next.sp = regs.sp - 16'd2;
    regs_next.pc = ((cur.kind == K_JP) ? idx : regs.pc) + {14'd0, cur.adv};
    regs_next.r  = {regs.r[7], regs.r[6:0] + 7'd1};
  end

  always_comb begin
    stat.clearing = (state == ST_CLEAR);
    stat.pop      = q_valid && ((state == ST_IDLE) || fin_go);
  end

  always_ff @(posedge clk) begin
    if (stat.pop) cur <= q_item;
    if (fin_go) begin
      t_states       <= cur.tst;
      unknown_opcode <= (cur.kind == K_UNKNOWN);
      ix_value       <= regs_next.ix;
      iy_value       <= regs_next.iy;
      acc_and_flags  <= {regs_next.a, regs_next.f};
      bc_value       <= {regs_next.b, regs_next.c};
      de_value       <= {regs_next.d, regs_next.e};
      hl_value       <= {regs_next.h, regs_next.l};
      sp_value       <= regs_next.sp;
      pc_value       <= regs_next.pc;
      refresh_value  <= regs_next.r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      regs      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) regs <= regs_next;
      if (fin_go) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + {{(ADDRESS_BITS-1){1'b0}}, 1'b1};
          if (&clr_cnt) state <= ST_IDLE;
        end
        ST_IDLE:  if (q_valid) state <= ST_EXEC;
        ST_EXEC:  state <= ST_STEP2;
        ST_STEP2: state <= ST_FIN;
        ST_FIN: begin
          // advance straight into the next word when one waits
          if (fin_go) state <= q_valid ? ST_EXEC : ST_IDLE;
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/z80_index_prefix_executor.sv -----
// The execute sequencer runs each instruction through issue, second memory access
// and finish, sharing the single memory port; a stalled result holds it in finish.
// A new instruction issues only after the last one finishes; the queue holds two.
// Reset: synchronous; the register file clears to zero, then memory is cleared
// with in_stall high. Results wait in an output register.
`default_nettype none
module z80_index_prefix_executor #(
  parameter int ADDRESS_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              index_select,
  input  wire logic [7:0]        opcode,
  input  wire logic signed [7:0] displacement,
  input  wire logic [7:0]        immediate_low,
  input  wire logic [7:0]        immediate_high,
  input  wire logic [7:0]        bit_opcode,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [4:0]             t_states,
  output logic                   unknown_opcode,
  output logic [15:0]            ix_value,
  output logic [15:0]            iy_value,
  output logic [15:0]            acc_and_flags,
  output logic [15:0]            bc_value,
  output logic [15:0]            de_value,
  output logic [15:0]            hl_value,
  output logic [15:0]            sp_value,
  output logic [15:0]            pc_value,
  output logic [7:0]             refresh_value
);
  import zipe_pkg::*;

  exec_stat_t stat;
  logic       q_valid;
  item_t      q_item;

  zipe_front u_front (
    .clk, .rst, .in_valid, .in_stall, .index_select, .opcode, .displacement,
    .immediate_low, .immediate_high, .bit_opcode, .stat, .q_valid, .q_item
  );

  zipe_exec #(.ADDRESS_BITS(ADDRESS_BITS)) u_exec (
    .clk, .rst, .q_valid, .q_item, .stat, .out_valid, .out_stall, .t_states,
    .unknown_opcode, .ix_value, .iy_value, .acc_and_flags, .bc_value, .de_value,
    .hl_value, .sp_value, .pc_value, .refresh_value
  );

endmodule
`default_nettype wire

// ----- rtl/core/zipe_checker.sv -----
`default_nettype none
`include "z80_index_prefix_executor_assert.svh"
module zipe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [4:0]  t_states,
  input wire logic        unknown_opcode,
  input wire logic [15:0] pc_value,
  input wire logic [7:0]  refresh_value
);
  // hold a stalled result word
  `ZIPE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pc_value))
  `ZIPE_ASSERT_NOW(a_unknown_t, out_valid, unknown_opcode == (t_states == 5'd0))
  `ZIPE_ASSERT_NOW(a_t_range, out_valid, t_states <= 5'd23)
  `ZIPE_ASSERT_NOW(a_r_top, out_valid, !refresh_value[7])
endmodule

bind z80_index_prefix_executor zipe_checker u_chk (.*);
`default_nettype wire

// ----- tb/sv/z80_index_prefix_executor_test.sv -----
`timescale 1ns / 100ps
module z80_index_prefix_executor_test;
  import zipe_pkg::*;

  localparam logic [7:0] OP_ADD_BC     = 8'h09;
  localparam logic [7:0] OP_ADD_DE     = 8'h19;
  localparam logic [7:0] OP_LD_IDX_NN  = 8'h21;
  localparam logic [7:0] OP_ST_IDX_MEM = 8'h22;
  localparam logic [7:0] OP_INC_IDX    = 8'h23;
  localparam logic [7:0] OP_INC_IDXH   = 8'h24;
  localparam logic [7:0] OP_LD_IDXH_N  = 8'h26;
  localparam logic [7:0] OP_ADD_IDX    = 8'h29;
  localparam logic [7:0] OP_LD_IDX_MEM = 8'h2A;
  localparam logic [7:0] OP_DEC_IDX    = 8'h2B;
  localparam logic [7:0] OP_LD_IDXL_N  = 8'h2E;
  localparam logic [7:0] OP_INC_MEM    = 8'h34;
  localparam logic [7:0] OP_DEC_MEM    = 8'h35;
  localparam logic [7:0] OP_LD_MEM_N   = 8'h36;
  localparam logic [7:0] OP_ADD_SP     = 8'h39;
  localparam logic [7:0] OP_LD_B_MEM   = 8'h46;
  localparam logic [7:0] OP_LD_C_IDXH  = 8'h4C;
  localparam logic [7:0] OP_LD_D_IDXH  = 8'h54;
  localparam logic [7:0] OP_LD_E_IDXH  = 8'h5C;
  localparam logic [7:0] OP_LD_E_IDXL  = 8'h5D;
  localparam logic [7:0] OP_LD_IDXH_B  = 8'h60;
  localparam logic [7:0] OP_LD_IDXL_C  = 8'h69;
  localparam logic [7:0] OP_LD_IDXL_A  = 8'h6F;
  localparam logic [7:0] OP_LD_IDXH_A  = 8'h67;
  localparam logic [7:0] OP_LD_MEM_B   = 8'h70;
  localparam logic [7:0] OP_HALT       = 8'h76;
  localparam logic [7:0] OP_LD_MEM_A   = 8'h77;
  localparam logic [7:0] OP_LD_A_IDXH  = 8'h7C;
  localparam logic [7:0] OP_LD_A_IDXL  = 8'h7D;
  localparam logic [7:0] OP_LD_A_MEM   = 8'h7E;
  localparam logic [7:0] OP_ADD_MEM    = 8'h86;
  localparam logic [7:0] OP_SUB_MEM    = 8'h96;
  localparam logic [7:0] OP_CP_MEM     = 8'hBE;
  localparam logic [7:0] OP_OR_IDXL    = 8'hB5;
  localparam logic [7:0] OP_POP_IDX    = 8'hE1;
  localparam logic [7:0] OP_PUSH_IDX   = 8'hE5;
  localparam logic [7:0] OP_JP_IDX     = 8'hE9;
  localparam logic [7:0] OP_NOP        = 8'h00;
  localparam logic [7:0] CB_RLC        = 8'h00;
  localparam logic [7:0] CB_BIT7       = 8'h7E;
  localparam logic [7:0] CB_RES0       = 8'h86;
  localparam logic [7:0] CB_SET7       = 8'hFE;
  localparam logic [7:0] CB_BIT_FIRST  = 8'h40;
  localparam logic [7:0] CB_RES_FIRST  = 8'h80;
  localparam logic [7:0] CB_SET_FIRST  = 8'hC0;
  localparam logic [2:0] MEM_OPERAND   = 3'b110;

  localparam int R_A = 0, R_F = 1, R_B = 2, R_C = 3, R_D = 4, R_E = 5, R_H = 6, R_L = 7;
  localparam logic [7:0] FL_S = 8'h80, FL_Z = 8'h40, FL_H = 8'h10;
  localparam logic [7:0] FL_P = 8'h04, FL_N = 8'h02, FL_C = 8'h01;
  localparam int IDLE_LIMIT = 200000;

  typedef struct {
    logic       sel;
    logic [7:0] op;
    logic [7:0] disp;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] cb;
  } instr_t;

  typedef struct {
    logic [4:0]  t;
    logic        unk;
    logic [15:0] ix, iy, af, bc, de, hl, sp, pc;
    logic [7:0]  r;
  } cpu_view_t;

  class index_exec_scoreboard;
    logic [7:0]  mem [65536];
    logic [7:0]  rf [8];
    logic [15:0] ix, iy, sp, pc;
    logic [7:0]  rr;
    cpu_view_t   pending_views [$];
    int          errors;
    int          checked;
    int          unknowns;

    function new();
      foreach (mem[i]) mem[i] = '0;
      foreach (rf[i]) rf[i] = '0;
      ix = '0; iy = '0; sp = '0; pc = '0; rr = '0;
      errors = 0; checked = 0; unknowns = 0;
    endfunction

    function logic [7:0] sz(logic [7:0] r);
      return (r & FL_S) | ((r == 8'h00) ? FL_Z : 8'h00);
    endfunction

    function logic [7:0] inc_dec8(logic [7:0] v, bit dec);
      logic [7:0] r;
      logic [7:0] f;
      r = dec ? v - 8'd1 : v + 8'd1;
      f = (rf[R_F] & (8'h28 | FL_C)) | sz(r);
      if (dec) begin
        f |= FL_N;
        if (r[3:0] == 4'hF) f |= FL_H;
        if (r == 8'h7F) f |= FL_P;
      end else begin
        if (r[3:0] == 4'h0) f |= FL_H;
        if (r == 8'h80) f |= FL_P;
      end
      rf[R_F] = f;
      return r;
    endfunction

    function void alu8(alu_op_t aop, logic [7:0] v);
      int a, b, c, r;
      logic [7:0] nf;
      a = rf[R_A]; b = v;
      c = (aop == ALU_ADC || aop == ALU_SBC) ? int'(rf[R_F][0]) : 0;
      nf = rf[R_F] & 8'h28;
      if (aop == ALU_ADD || aop == ALU_ADC) begin
        r = a + b + c;
        if ((a % 16) + (b % 16) + c > 15) nf |= FL_H;
        if (((~(a ^ b)) & (a ^ r) & 'h80) != 0) nf |= FL_P;
        if (r > 255) nf |= FL_C;
        nf |= sz(r[7:0]);
      end else if (aop == ALU_SUB || aop == ALU_SBC || aop == ALU_CP) begin
        r = (a + 512 - b - c) % 512;
        if ((a % 16) < (b % 16) + c) nf |= FL_H;
        if (((a ^ b) & (a ^ r) & 'h80) != 0) nf |= FL_P;
        if (a < b + c) nf |= FL_C;
        nf |= FL_N | sz(r[7:0]);
      end else begin
        if (aop == ALU_AND) begin
          r = a & b; nf |= FL_H;
        end else if (aop == ALU_XOR) r = a ^ b;
        else r = a | b;
        nf |= sz(r[7:0]) | ((^r[7:0]) ? 8'h00 : FL_P);
      end
      if (aop != ALU_CP) rf[R_A] = r[7:0];
      rf[R_F] = nf;
    endfunction

    function logic [15:0] add16(logic [15:0] x, logic [15:0] y);
      logic [16:0] r;
      logic [7:0] f;
      r = x + y;
      f = rf[R_F] & ~(FL_H | FL_N | FL_C);
      if ({1'b0, x[11:0]} + {1'b0, y[11:0]} > 13'hFFF) f |= FL_H;
      if (r[16]) f |= FL_C;
      rf[R_F] = f;
      return r[15:0];
    endfunction

    function int reg_index(logic [2:0] code);
      return (code == REG_A) ? R_A : int'(code) + 2;
    endfunction

    function cpu_view_t execute(instr_t w);
      cpu_view_t  res;
      logic [15:0] xr, ea, nn, adv;
      logic [7:0] v, f;
      logic [4:0] t;
      logic [2:0] bn;
      xr = w.sel ? iy : ix;
      nn = {w.hi, w.lo};
      ea = xr + {{8{w.disp[7]}}, w.disp};
      adv = 16'd1;
      t = 5'd0;
      rr = {rr[7], rr[6:0] + 7'd1};
      case (w.op)
        OP_LD_IDX_NN: begin adv += 2; xr = nn; t = 14; end
        OP_ST_IDX_MEM: begin
          adv += 2; mem[nn] = xr[7:0]; mem[nn + 16'd1] = xr[15:8]; t = 20;
        end
        OP_LD_IDX_MEM: begin
          adv += 2; xr = {mem[nn + 16'd1], mem[nn]}; t = 20;
        end
        OP_ADD_BC: begin xr = add16(xr, {rf[R_B], rf[R_C]}); t = 15; end
        OP_ADD_DE: begin xr = add16(xr, {rf[R_D], rf[R_E]}); t = 15; end
        OP_ADD_IDX: begin xr = add16(xr, xr); t = 15; end
        OP_ADD_SP: begin xr = add16(xr, sp); t = 15; end
        OP_INC_IDX: begin xr = xr + 16'd1; t = 10; end
        OP_DEC_IDX: begin xr = xr - 16'd1; t = 10; end
        OP_INC_IDXH: begin xr[15:8] = inc_dec8(xr[15:8], 1'b0); t = 8; end
        OP_LD_IDXH_N: begin adv += 1; xr[15:8] = w.lo; t = 11; end
        OP_LD_IDXL_N: begin adv += 1; xr[7:0] = w.lo; t = 11; end
        OP_LD_D_IDXH: begin rf[R_D] = xr[15:8]; t = 8; end
        OP_LD_E_IDXL: begin rf[R_E] = xr[7:0]; t = 8; end
        OP_LD_E_IDXH: begin rf[R_E] = xr[15:8]; t = 8; end
        OP_LD_C_IDXH: begin rf[R_C] = xr[15:8]; t = 8; end
        OP_LD_A_IDXH: begin rf[R_A] = xr[15:8]; t = 8; end
        OP_LD_A_IDXL: begin rf[R_A] = xr[7:0]; t = 8; end
        OP_LD_IDXL_C: begin xr[7:0] = rf[R_C]; t = 8; end
        OP_LD_IDXL_A: begin xr[7:0] = rf[R_A]; t = 8; end
        OP_LD_IDXH_B: begin xr[15:8] = rf[R_B]; t = 8; end
        OP_LD_IDXH_A: begin xr[15:8] = rf[R_A]; t = 8; end
        OP_OR_IDXL: begin alu8(ALU_OR, xr[7:0]); t = 8; end
        OP_INC_MEM: begin adv += 1; mem[ea] = inc_dec8(mem[ea], 1'b0); t = 23; end
        OP_DEC_MEM: begin adv += 1; mem[ea] = inc_dec8(mem[ea], 1'b1); t = 23; end
        OP_LD_MEM_N: begin adv += 2; mem[ea] = w.lo; t = 19; end
        OP_JP_IDX: begin pc = xr; adv = 0; t = 8; end
        OP_POP_IDX: begin
          xr[7:0] = mem[sp]; sp += 16'd1;
          xr[15:8] = mem[sp]; sp += 16'd1;
          t = 14;
        end
        OP_PUSH_IDX: begin
          sp -= 16'd1; mem[sp] = xr[15:8];
          sp -= 16'd1; mem[sp] = xr[7:0];
          t = 15;
        end
        OP_CB: begin
          adv += 2; bn = w.cb[5:3]; v = mem[ea];
          if (w.cb >= CB_SET_FIRST) begin
            mem[ea] = v | (8'd1 << bn); t = 23;
          end else if (w.cb >= CB_RES_FIRST) begin
            mem[ea] = v & ~(8'd1 << bn); t = 23;
          end else if (w.cb >= CB_BIT_FIRST) begin
            f = (rf[R_F] & ~(FL_Z | FL_N)) | FL_H;
            if (!v[bn]) f |= FL_Z;
            rf[R_F] = f; t = 20;
          end
        end
        default: begin
          if (w.op[7:6] == 2'b01 && w.op[2:0] == MEM_OPERAND && w.op != OP_HALT) begin
            adv += 1; rf[reg_index(w.op[5:3])] = mem[ea]; t = 19;
          end else if (w.op[7:6] == 2'b01 && w.op[5:3] == MEM_OPERAND &&
                       w.op[2:0] != MEM_OPERAND) begin
            adv += 1; mem[ea] = rf[reg_index(w.op[2:0])]; t = 19;
          end else if (w.op[7:6] == 2'b10 && w.op[2:0] == MEM_OPERAND) begin
            adv += 1; alu8(alu_op_t'(w.op[5:3]), mem[ea]); t = 19;
          end
        end
      endcase
      if (w.sel) iy = xr;
      else ix = xr;
      pc += adv;
      res.t = t; res.unk = (t == 0);
      res.ix = ix; res.iy = iy;
      res.af = {rf[R_A], rf[R_F]}; res.bc = {rf[R_B], rf[R_C]};
      res.de = {rf[R_D], rf[R_E]}; res.hl = {rf[R_H], rf[R_L]};
      res.sp = sp; res.pc = pc; res.r = rr;
      return res;
    endfunction

    function void note_instr(instr_t w);
      cpu_view_t e;
      e = execute(w);
      if (e.unk) unknowns++;
      pending_views.push_back(e);
    endfunction

    function void cmp(string name, logic [15:0] e, logic [15:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s expected %h got %h", $time, name, e, a);
      end
    endfunction

    function void check_view(cpu_view_t a);
      cpu_view_t e;
      if (pending_views.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected", $time);
        return;
      end
      e = pending_views.pop_front();
      checked++;
      cmp("t_states", e.t, a.t);
      cmp("unknown_opcode", e.unk, a.unk);
      cmp("ix_value", e.ix, a.ix);
      cmp("iy_value", e.iy, a.iy);
      cmp("acc_and_flags", e.af, a.af);
      cmp("bc_value", e.bc, a.bc);
      cmp("de_value", e.de, a.de);
      cmp("hl_value", e.hl, a.hl);
      cmp("sp_value", e.sp, a.sp);
      cmp("pc_value", e.pc, a.pc);
      cmp("refresh_value", e.r, a.r);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic index_select = 1'b0;
  logic [7:0] opcode = '0;
  logic [7:0] displacement = '0;
  logic [7:0] immediate_low = '0;
  logic [7:0] immediate_high = '0;
  logic [7:0] bit_opcode = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [4:0] t_states;
  logic unknown_opcode;
  logic [15:0] ix_value, iy_value, acc_and_flags, bc_value, de_value, hl_value;
  logic [15:0] sp_value, pc_value;
  logic [7:0] refresh_value;

  index_exec_scoreboard sb;
  logic [7:0] handled_ops [$];
  int idle_cycles = 0;
  int results_seen = 0;
  bit long_hold_done = 1'b0;

  z80_index_prefix_executor u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .index_select(index_select), .opcode(opcode), .displacement(displacement),
    .immediate_low(immediate_low), .immediate_high(immediate_high),
    .bit_opcode(bit_opcode),
    .out_valid(out_valid), .out_stall(out_stall),
    .t_states(t_states), .unknown_opcode(unknown_opcode),
    .ix_value(ix_value), .iy_value(iy_value), .acc_and_flags(acc_and_flags),
    .bc_value(bc_value), .de_value(de_value), .hl_value(hl_value),
    .sp_value(sp_value), .pc_value(pc_value), .refresh_value(refresh_value)
  );

  always #5 clk = ~clk;

  // Note accepted words on both sides and watch for a hang.
  always @(posedge clk) begin
    cpu_view_t got;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_instr('{index_select, opcode, displacement, immediate_low,
                        immediate_high, bit_opcode});
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got.t = t_states; got.unk = unknown_opcode;
        got.ix = ix_value; got.iy = iy_value; got.af = acc_and_flags;
        got.bc = bc_value; got.de = de_value; got.hl = hl_value;
        got.sp = sp_value; got.pc = pc_value; got.r = refresh_value;
        sb.check_view(got);
        results_seen++;
        moved = 1'b1;
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off once results are flowing.
  initial begin
    int r;
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 55) hold = 0;
      else if (r < 92) hold = $urandom_range(1, 3);
      else hold = $urandom_range(10, 50);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  task automatic send_instr(instr_t w, int gap);
    in_valid <= 1'b1;
    index_select <= w.sel;
    opcode <= w.op;
    displacement <= w.disp;
    immediate_low <= w.lo;
    immediate_high <= w.hi;
    bit_opcode <= w.cb;
    do @(posedge clk); while (in_stall);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_views.size() != 0) @(posedge clk);
  endtask

  function automatic instr_t random_instr();
    instr_t w;
    int r;
    w.sel = $urandom_range(0, 1);
    w.disp = $urandom_range(0, 255);
    w.lo = $urandom_range(0, 255);
    w.hi = $urandom_range(0, 255);
    w.cb = $urandom_range(0, 255);
    r = $urandom_range(0, 99);
    if (r < 12) w.op = $urandom_range(0, 255);
    else w.op = handled_ops[$urandom_range(0, handled_ops.size() - 1)];
    // keep the index registers and nn addresses mostly in a small window
    // so that stores and loads meet
    if (r >= 12 && r < 20) w.op = OP_LD_IDX_NN;
    if ((w.op == OP_LD_IDX_NN || w.op == OP_ST_IDX_MEM || w.op == OP_LD_IDX_MEM) &&
        $urandom_range(0, 3) != 0)
      w.hi = 8'h40 + $urandom_range(0, 1);
    return w;
  endfunction

  initial begin
    index_exec_scoreboard probe;
    instr_t w;
    int gap_mode;
    probe = new();
    sb = new();
    for (int i = 0; i < 256; i++) begin
      w = '{1'b0, i[7:0], 8'h00, 8'h00, 8'h00, CB_BIT_FIRST};
      if (!probe.execute(w).unk) handled_ops.push_back(i[7:0]);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_instr('{1'b0, OP_LD_IDX_NN, 8'h00, 8'hFF, 8'hFF, 8'h00}, 0);
    send_instr('{1'b1, OP_LD_IDX_NN, 8'h00, 8'h00, 8'h00, 8'h00}, 1);
    send_instr('{1'b1, OP_LD_MEM_N, 8'h80, 8'h7F, 8'h00, 8'h00}, 0);
    send_instr('{1'b1, OP_INC_MEM, 8'h80, 8'h00, 8'h00, 8'h00}, 0);
    send_instr('{1'b1, OP_LD_A_MEM, 8'h80, 8'h00, 8'h00, 8'h00}, 2);
    send_instr('{1'b1, OP_DEC_MEM, 8'h80, 8'h00, 8'h00, 8'h00}, 0);
    send_instr('{1'b1, OP_DEC_MEM, 8'h7F, 8'h00, 8'h00, 8'h00}, 0);
    send_instr('{1'b0, OP_LD_MEM_N, 8'h7F, 8'hFF, 8'h00, 8'h00}, 0);
    send_instr('{1'b0, OP_ADD_MEM, 8'h7F, 8'h00, 8'h00, 8'h00}, 0);
    send_instr('{1'b0, OP_SUB_MEM, 8'h7F, 8'h00, 8'h00, 8'h00}, 0);
    send_instr('{1'b0, OP_CP_MEM, 8'h7F, 8'h00, 8'h00, 8'h00}, 0);
    send_instr('{1'b0, OP_ADD_IDX, 8'h00, 8'h00, 8'h00, 8'h00}, 0);
    send_instr('{1'b0, OP_ST_IDX_MEM, 8'h00, 8'hFF, 8'hFF, 8'h00}, 0);
    send_instr('{1'b1, OP_LD_IDX_MEM, 8'h00, 8'hFF, 8'hFF, 8'h00}, 0);
    send_instr('{1'b0, OP_PUSH_IDX, 8'h00, 8'h00, 8'h00, 8'h00}, 0);
    send_instr('{1'b1, OP_POP_IDX, 8'h00, 8'h00, 8'h00, 8'h00}, 0);
    send_instr('{1'b1, OP_CB, 8'h80, 8'h00, 8'h00, CB_SET7}, 0);
    send_instr('{1'b1, OP_CB, 8'h80, 8'h00, 8'h00, CB_BIT7}, 0);
    send_instr('{1'b1, OP_CB, 8'h80, 8'h00, 8'h00, CB_RES0}, 0);
    send_instr('{1'b1, OP_CB, 8'h80, 8'h00, 8'h00, CB_RLC}, 0);
    send_instr('{1'b0, OP_NOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 0);
    send_instr('{1'b0, OP_INC_IDXH, 8'h00, 8'h00, 8'h00, 8'h00}, 0);
    send_instr('{1'b1, OP_OR_IDXL, 8'h00, 8'h00, 8'h00, 8'h00}, 0);
    send_instr('{1'b1, OP_JP_IDX, 8'h00, 8'h00, 8'h00, 8'h00}, 0);
    drain();

    gap_mode = 0;
    for (int i = 0; i < 1200; i++) begin
      int gap, r;
      if (i % 100 == 0) gap_mode = $urandom_range(0, 2);
      if (i == 700) drain();
      r = $urandom_range(0, 99);
      if (gap_mode == 0 || r < 60) gap = 0;
      else if (r < 93) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      send_instr(random_instr(), gap);
    end
    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d instructions, %0d unknown, through long output hold-off and drains",
             sb.checked, sb.unknowns);
    if (sb.errors == 0 && sb.pending_views.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
